// ===== rtl/core/wlp_pkg.sv =====
// shared constants, codes, control structs and latency helper for the percentile block
package wlp_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int TS_W          = 64;
  localparam int LAT_W         = 32;
  localparam int QUEUE_W       = 32;
  localparam int REC_W         = 64;
  localparam int COUNT_OUT_W   = 11;
  localparam int BIT_W         = 5;
  localparam int PCT_DIV       = 100;
  localparam int PCT_DIV_W     = 7;

  // 2^32/100 rounded up: (x*PCT_RECIP) >> PCT_RECIP_SH is x/100 exactly for x below 2^30
  localparam int PCT_RECIP     = 42949673;
  localparam int PCT_RECIP_SH  = 32;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] METRIC_TOTAL     = 2'd0;
  localparam logic [1:0] METRIC_OVERSHOOT = 2'd1;
  localparam logic [1:0] METRIC_QUEUE     = 2'd2;

  localparam int PCT_50 = 50;
  localparam int PCT_95 = 95;
  localparam int PCT_99 = 99;

  // rank steps done by reciprocal multiply, average by the serial divider
  typedef enum logic [1:0] {
    DIV_P50,
    DIV_P95,
    DIV_P99,
    DIV_AVG
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    record;
    logic    clear;
    logic    query_start;
    logic    rd_en;
    logic    commit;
    logic    div_start;
    div_op_t div_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic addr_last;
    logic bit_last;
    logic div_done;
  } status_t;

  // difference of two stamps, zero when absent or not later, saturated
  function automatic logic [LAT_W-1:0] latency(input logic [TS_W-1:0] early,
                                               input logic [TS_W-1:0] late);
    logic [TS_W-1:0] d;
    d = late - early;
    if (early == '0 || late == '0 || late <= early) begin
      return '0;
    end else if (d[TS_W-1:LAT_W] != '0) begin
      return '1;
    end else begin
      return d[LAT_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/wlp_div.sv =====
// serial restoring divider, one quotient bit per cycle
module wlp_div #(
  parameter int DDW = 42,
  parameter int DVW = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DDW-1:0] quotient
);

  localparam int CW = $clog2(DDW + 1);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;

  // shift in next dividend bit and try the subtract
  assign trial = {rem, quotient[DDW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DDW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= diff[DVW-1:0];
        quotient <= {quotient[DDW-2:0], 1'b1};
      end else begin
        rem      <= trial[DVW-1:0];
        quotient <= {quotient[DDW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/wlp_dp.sv =====
// datapath: sample stores, counters, scan accumulators, radix select and result registers
module wlp_dp #(
  parameter int DEPTH = wlp_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wlp_pkg::cmd_t                     cmd,
  output wlp_pkg::status_t                  status,
  input  logic                              cfg_valid,
  input  logic                              cfg_data,
  input  logic [wlp_pkg::TS_W-1:0]          request_time,
  input  logic [wlp_pkg::TS_W-1:0]          fire_time,
  input  logic [wlp_pkg::TS_W-1:0]          reactor_start_time,
  input  logic [wlp_pkg::TS_W-1:0]          walk_check_time,
  input  logic [wlp_pkg::TS_W-1:0]          move_time,
  input  logic [wlp_pkg::QUEUE_W-1:0]       queue_pending,
  input  logic [1:0]                        metric_select,
  output logic [wlp_pkg::COUNT_OUT_W-1:0]   sample_count,
  output logic [wlp_pkg::LAT_W-1:0]         min_value,
  output logic [wlp_pkg::LAT_W-1:0]         max_value,
  output logic [wlp_pkg::LAT_W-1:0]         avg_value,
  output logic [wlp_pkg::LAT_W-1:0]         p50_value,
  output logic [wlp_pkg::LAT_W-1:0]         p95_value,
  output logic [wlp_pkg::LAT_W-1:0]         p99_value,
  output logic [wlp_pkg::QUEUE_W-1:0]       max_queue_seen,
  output logic [wlp_pkg::REC_W-1:0]         records_total
);

  localparam int LW   = wlp_pkg::LAT_W;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int DDW  = LW + CNTW;
  localparam int DVW  = (CNTW > wlp_pkg::PCT_DIV_W) ? CNTW : wlp_pkg::PCT_DIV_W;
  localparam int EXTW = CNTW + wlp_pkg::COUNT_OUT_W;
  localparam int PXW  = CNTW + wlp_pkg::PCT_DIV_W;
  localparam int SH   = wlp_pkg::PCT_RECIP_SH;

  // sample stores
  logic [LW-1:0] total_store [DEPTH];
  logic [LW-1:0] over_store  [DEPTH];
  logic [LW-1:0] qdel_store  [DEPTH];

  logic                       sample_enable;
  logic [AW-1:0]              wp;
  logic [CNTW-1:0]            filled;
  logic [wlp_pkg::REC_W-1:0]  rec_cnt;
  logic [wlp_pkg::QUEUE_W-1:0] q_peak;

  // query context
  logic [1:0]      q_sel;
  logic [CNTW-1:0] q_n;
  logic            q_empty;
  logic [AW-1:0]   rd_addr;
  logic            dvalid;
  logic [LW-1:0]   rd_total;
  logic [LW-1:0]   rd_over;
  logic [LW-1:0]   rd_qdel;
  logic [LW-1:0]   rdata;
  logic [wlp_pkg::BIT_W-1:0] bit_idx;
  logic            first_pass;

  logic [LW-1:0]   acc_min;
  logic [LW-1:0]   acc_max;
  logic [DDW-1:0]  acc_sum;
  logic [LW-1:0]   avg_q;

  logic [CNTW-1:0] rank   [3];
  logic [CNTW-1:0] cnt0   [3];
  logic [LW-1:0]   prefix [3];

  logic [CNTW-1:0] n_m1;
  logic [5:0]      bp1;
  logic [LW:0]     low_mask;
  logic [LW-1:0]   hi_mask;

  logic [DVW-1:0]  div_divisor;
  logic            div_done;
  logic [DDW-1:0]  div_quot;
  logic [CNTW-1:0] rank_new;
  logic [EXTW-1:0] n_ext;

  logic [PXW-1:0]    pct_num;
  logic [PXW-1:0]    pct_x;
  logic [PXW+SH-1:0] pct_prod;
  logic [PXW-1:0]    pct_q;
  logic              pct_run;
  logic              pct_done;
  logic              step_done;
  logic [DDW-1:0]    quot;

  assign n_m1     = q_n - 1'b1;
  assign bp1      = {1'b0, bit_idx} + 6'd1;
  assign low_mask = ((LW+1)'(1) << bp1) - (LW+1)'(1);
  assign hi_mask  = ~low_mask[LW-1:0];
  assign first_pass = (bit_idx == wlp_pkg::BIT_W'(LW - 1));
  assign n_ext    = EXTW'(q_n);

  assign step_done = div_done || pct_done;
  assign quot      = pct_done ? DDW'(pct_q) : div_quot;

  assign status.empty     = q_empty;
  assign status.addr_last = (rd_addr == n_m1[AW-1:0]);
  assign status.bit_last  = (bit_idx == '0);
  assign status.div_done  = step_done;

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_enable <= 1'b0;
    end else if (cfg_valid) begin
      sample_enable <= cfg_data;
    end
  end

  // ring pointer, fill count, record counter and queue peak
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      filled  <= '0;
      rec_cnt <= '0;
      q_peak  <= '0;
    end else if (cmd.clear) begin
      wp      <= '0;
      filled  <= '0;
      rec_cnt <= '0;
      q_peak  <= '0;
    end else if (cmd.record && sample_enable) begin
      wp      <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (filled != CNTW'(DEPTH)) begin
        filled <= filled + 1'b1;
      end
      rec_cnt <= rec_cnt + 1'b1;
      if (queue_pending > q_peak) begin
        q_peak <= queue_pending;
      end
    end
  end

  // store writes on record, registered reads for the scan
  always_ff @(posedge clk) begin
    if (cmd.record && sample_enable) begin
      total_store[wp] <= wlp_pkg::latency(request_time, move_time);
      over_store[wp]  <= wlp_pkg::latency(fire_time, reactor_start_time);
      qdel_store[wp]  <= wlp_pkg::latency(reactor_start_time, walk_check_time);
    end
    rd_total <= total_store[rd_addr];
    rd_over  <= over_store[rd_addr];
    rd_qdel  <= qdel_store[rd_addr];
  end

  always_comb begin
    unique case (q_sel)
      wlp_pkg::METRIC_TOTAL:     rdata = rd_total;
      wlp_pkg::METRIC_OVERSHOOT: rdata = rd_over;
      default:                   rdata = rd_qdel;
    endcase
  end

  // rank numerators n*p + 99, so that the quotient by 100 is the ceiling
  always_comb begin
    unique case (cmd.div_op)
      wlp_pkg::DIV_P50: pct_num = PXW'(q_n) * PXW'(wlp_pkg::PCT_50) + PXW'(wlp_pkg::PCT_DIV - 1);
      wlp_pkg::DIV_P95: pct_num = PXW'(q_n) * PXW'(wlp_pkg::PCT_95) + PXW'(wlp_pkg::PCT_DIV - 1);
      wlp_pkg::DIV_P99: pct_num = PXW'(q_n) * PXW'(wlp_pkg::PCT_99) + PXW'(wlp_pkg::PCT_DIV - 1);
      default:          pct_num = '0;
    endcase
  end

  assign div_divisor = DVW'(q_n);

  // division by 100 as a reciprocal multiply: numerator registered in pct_x, quotient in pct_q, flagged by pct_done
  assign pct_prod = (PXW+SH)'(pct_x) * (PXW+SH)'(wlp_pkg::PCT_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pct_run  <= 1'b0;
      pct_done <= 1'b0;
    end else begin
      pct_run  <= cmd.div_start && (cmd.div_op != wlp_pkg::DIV_AVG);
      pct_done <= pct_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      pct_x <= pct_num;
    end
    pct_q <= pct_prod[PXW+SH-1:SH];
  end

  // rank = ceil(n*p/100) - 1, limited to n - 1
  always_comb begin
    if (quot == '0) begin
      rank_new = '0;
    end else if (quot > DDW'(q_n)) begin
      rank_new = n_m1;
    end else begin
      rank_new = CNTW'(quot - 1'b1);
    end
  end

  wlp_div #(
    .DDW (DDW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && (cmd.div_op == wlp_pkg::DIV_AVG)),
    .dividend (acc_sum),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // scan control and read valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else begin
      dvalid <= cmd.rd_en;
    end
  end

  // query accumulators and radix select
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_sel   <= metric_select;
      q_n     <= filled;
      q_empty <= (metric_select != wlp_pkg::METRIC_TOTAL &&
                  metric_select != wlp_pkg::METRIC_OVERSHOOT &&
                  metric_select != wlp_pkg::METRIC_QUEUE) || (filled == '0);
      rd_addr <= '0;
      bit_idx <= wlp_pkg::BIT_W'(LW - 1);
      acc_min <= '1;
      acc_max <= '0;
      acc_sum <= '0;
      for (int j = 0; j < 3; j++) begin
        cnt0[j]   <= '0;
        prefix[j] <= '0;
      end
    end else begin
      if (cmd.rd_en) begin
        rd_addr <= rd_addr + 1'b1;
      end
      // count elements under each prefix whose current bit is zero
      if (dvalid) begin
        for (int j = 0; j < 3; j++) begin
          if (((rdata & hi_mask) == prefix[j]) && !rdata[bit_idx]) begin
            cnt0[j] <= cnt0[j] + 1'b1;
          end
        end
        if (first_pass) begin
          if (rdata < acc_min) acc_min <= rdata;
          if (rdata > acc_max) acc_max <= rdata;
          acc_sum <= acc_sum + DDW'(rdata);
        end
      end
      // decide one bit of each percentile at pass end
      if (cmd.commit) begin
        for (int j = 0; j < 3; j++) begin
          if (rank[j] >= cnt0[j]) begin
            prefix[j][bit_idx] <= 1'b1;
            rank[j]            <= rank[j] - cnt0[j];
          end
          cnt0[j] <= '0;
        end
        rd_addr <= '0;
        bit_idx <= bit_idx - 1'b1;
      end
      if (step_done) begin
        unique case (cmd.div_op)
          wlp_pkg::DIV_P50: rank[0] <= rank_new;
          wlp_pkg::DIV_P95: rank[1] <= rank_new;
          wlp_pkg::DIV_P99: rank[2] <= rank_new;
          default:          avg_q   <= quot[LW-1:0];
        endcase
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      max_queue_seen <= q_peak;
      records_total  <= rec_cnt;
      if (q_empty) begin
        sample_count <= '0;
        min_value    <= '0;
        max_value    <= '0;
        avg_value    <= '0;
        p50_value    <= '0;
        p95_value    <= '0;
        p99_value    <= '0;
      end else begin
        sample_count <= n_ext[wlp_pkg::COUNT_OUT_W-1:0];
        min_value    <= acc_min;
        max_value    <= acc_max;
        avg_value    <= avg_q;
        p50_value    <= prefix[0];
        p95_value    <= prefix[1];
        p99_value    <= prefix[2];
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CNTW'(DEPTH))
    else $error("fill count beyond window depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= AW'(DEPTH - 1))
    else $error("write pointer beyond window");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (rank[0] < q_n && rank[1] < q_n && rank[2] < q_n))
    else $error("percentile rank outside window");

endmodule

// ===== rtl/core/wlp_ctrl.sv =====
// controller: transaction decode and query sequencing
module wlp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  output logic             out_valid,
  input  logic             out_stall,
  output wlp_pkg::cmd_t    cmd,
  input  wlp_pkg::status_t status
);

  wlp_pkg::state_t  state;
  wlp_pkg::state_t  state_next;
  wlp_pkg::div_op_t op;
  wlp_pkg::div_op_t op_next;
  logic             out_valid_next;
  logic             accept;

  assign in_stall = (state != wlp_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlp_pkg::ST_IDLE;
      op        <= wlp_pkg::DIV_P50;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    op_next          = op;
    cmd              = '0;
    cmd.div_op       = op;
    out_valid_next   = out_valid && out_stall;
    unique case (state)
      wlp_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.record = (mode == wlp_pkg::MODE_RECORD);
          cmd.clear  = (mode == wlp_pkg::MODE_CLEAR);
          if (mode == wlp_pkg::MODE_QUERY) begin
            cmd.query_start = 1'b1;
            state_next      = wlp_pkg::ST_START;
          end
        end
      end
      wlp_pkg::ST_START: begin
        if (status.empty) begin
          state_next = wlp_pkg::ST_DONE;
        end else begin
          op_next    = wlp_pkg::DIV_P50;
          state_next = wlp_pkg::ST_DIV;
        end
      end
      wlp_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = wlp_pkg::ST_DIV_WAIT;
      end
      wlp_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          unique case (op)
            wlp_pkg::DIV_P50: begin
              op_next    = wlp_pkg::DIV_P95;
              state_next = wlp_pkg::ST_DIV;
            end
            wlp_pkg::DIV_P95: begin
              op_next    = wlp_pkg::DIV_P99;
              state_next = wlp_pkg::ST_DIV;
            end
            wlp_pkg::DIV_P99: state_next = wlp_pkg::ST_SCAN;
            default:          state_next = wlp_pkg::ST_DONE;
          endcase
        end
      end
      wlp_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.addr_last) begin
          state_next = wlp_pkg::ST_DRAIN;
        end
      end
      wlp_pkg::ST_DRAIN: begin
        state_next = wlp_pkg::ST_COMMIT;
      end
      wlp_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (status.bit_last) begin
          op_next    = wlp_pkg::DIV_AVG;
          state_next = wlp_pkg::ST_DIV;
        end else begin
          state_next = wlp_pkg::ST_SCAN;
        end
      end
      wlp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = wlp_pkg::ST_IDLE;
        end
      end
      default: state_next = wlp_pkg::ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a pending transaction");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== rtl/core/windowed_latency_percentiles.sv =====
// top level of the windowed latency percentile block
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_valid/cfg_ready   cfg_data (sample enable)
//  in        in         in_valid/in_stall     mode, five timestamps, queue_pending, metric_select
//  out       out        out_valid/out_stall   count, min/max/avg, p50/p95/p99, queue peak, records
//
// record and clear transactions never stall the input; records are taken while a result waits
// a query runs, n the filled window: three reciprocal rank steps, one bit pass per latency
// bit, each of n reads then a drain and a decision state, and one serial division of the
// DDW-bit sample sum for the average, DDW = 32+clog2(DEPTH+1)
// an empty window or an unused metric skips rank steps, bit passes and division, going to ST_DONE
// rst is synchronous and active high; stores need no clearing pass, the fill count masks them
// a stalled result holds; the next query finishes and waits until that result is taken
module windowed_latency_percentiles #(
  parameter int DEPTH = wlp_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [wlp_pkg::TS_W-1:0]          request_time,
  input  logic [wlp_pkg::TS_W-1:0]          fire_time,
  input  logic [wlp_pkg::TS_W-1:0]          reactor_start_time,
  input  logic [wlp_pkg::TS_W-1:0]          walk_check_time,
  input  logic [wlp_pkg::TS_W-1:0]          move_time,
  input  logic [wlp_pkg::QUEUE_W-1:0]       queue_pending,
  input  logic [1:0]                        metric_select,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wlp_pkg::COUNT_OUT_W-1:0]   sample_count,
  output logic [wlp_pkg::LAT_W-1:0]         min_value,
  output logic [wlp_pkg::LAT_W-1:0]         max_value,
  output logic [wlp_pkg::LAT_W-1:0]         avg_value,
  output logic [wlp_pkg::LAT_W-1:0]         p50_value,
  output logic [wlp_pkg::LAT_W-1:0]         p95_value,
  output logic [wlp_pkg::LAT_W-1:0]         p99_value,
  output logic [wlp_pkg::QUEUE_W-1:0]       max_queue_seen,
  output logic [wlp_pkg::REC_W-1:0]         records_total
);

  wlp_pkg::cmd_t    cmd;
  wlp_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  wlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  wlp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .request_time       (request_time),
    .fire_time          (fire_time),
    .reactor_start_time (reactor_start_time),
    .walk_check_time    (walk_check_time),
    .move_time          (move_time),
    .queue_pending      (queue_pending),
    .metric_select      (metric_select),
    .sample_count       (sample_count),
    .min_value          (min_value),
    .max_value          (max_value),
    .avg_value          (avg_value),
    .p50_value          (p50_value),
    .p95_value          (p95_value),
    .p99_value          (p99_value),
    .max_queue_seen     (max_queue_seen),
    .records_total      (records_total)
  );

endmodule
